// File: src/rcrp_pkg.sv
// ----------------------------------------------------------------------------
// rcrp_pkg
// types, register codes and the distance function of the color region
// propagation block
// ----------------------------------------------------------------------------
package rcrp_pkg;

    localparam int LIMIT_W    = 18;
    localparam int WIDTH_W    = 11;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 2;

    localparam int LIMIT_ROOT = 20;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(LIMIT_ROOT * LIMIT_ROOT);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_LIMIT = 2'd0,
        CFG_IMAGE_WIDTH = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ORIGIN_SOURCE = 2'd0,
        ORIGIN_ABOVE  = 2'd1,
        ORIGIN_LEFT   = 2'd2
    } origin_t;

    // red sits in the low byte
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    localparam rgb_t BLACK = '{blue: 8'd0, green: 8'd0, red: 8'd0};

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return 16'(d) * 16'(d);
    endfunction

    function automatic logic [LIMIT_W-1:0] sq_dist(input rgb_t a, input rgb_t b);
        return LIMIT_W'(sq_diff(a.red, b.red))
             + LIMIT_W'(sq_diff(a.green, b.green))
             + LIMIT_W'(sq_diff(a.blue, b.blue));
    endfunction

endpackage

// File: src/raster_color_region_propagate_top.sv
// ----------------------------------------------------------------------------
// raster_color_region_propagate_top
// copies the nearer of the above and left output pixels when it lies within
// the squared color distance limit, else passes the source pixel
// ----------------------------------------------------------------------------
// path: the second stage with the distance compare, then the output register
// throughput: one pixel per clock unless the sink stalls, set by the left
//   pixel loop through the distance compare and the one line store read port
// reset: all control state clears at once, first row and column zero set,
//   limit 400 and width 1024; the line store needs no clearing pass
// ----------------------------------------------------------------------------
module raster_color_region_propagate_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [23:0]                    s_axis_tdata,
    // frame_start [0]
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // out_red [7:0], out_green [15:8], out_blue [23:16], color_origin [25:24]
    output logic [31:0]                    m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rcrp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcrp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rcrp_pkg::*;

    localparam int CNT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW    = (CNT_W + 1 > WIDTH_W) ? CNT_W + 1 : WIDTH_W;
    localparam logic [CW-1:0] MAX_W_C = CW'(MAX_WIDTH);

    // configuration
    logic [LIMIT_W-1:0] limit_reg;
    logic [WIDTH_W-1:0] width_reg;

    // front state
    logic [CNT_W-1:0] col_reg;
    logic             first_row_reg;

    // second stage
    logic             s1_valid_reg;
    rgb_t             s1_src_reg;
    logic [CNT_W-1:0] s1_col_reg;
    logic             s1_first_reg;
    logic             s1_fwd_reg;
    rgb_t             fwd_data_reg;
    rgb_t             left_reg;

    // output register
    logic             out_valid_reg;
    rgb_t             out_pix_reg;
    origin_t          out_origin_reg;

    // line store
    rgb_t             row_mem [MAX_WIDTH];
    rgb_t             rd_data_reg;

    logic             in_fire;
    logic             s1_fire;
    logic             cfg_fire;
    logic [CNT_W-1:0] col_eff;
    logic             first_eff;
    logic [CW-1:0]    width_ext;
    logic [CW-1:0]    eff_width;
    logic [CW-1:0]    col_plus;
    logic             row_wrap;

    rgb_t             above;
    rgb_t             left;
    logic [LIMIT_W-1:0] d_above;
    logic [LIMIT_W-1:0] d_left;
    logic [LIMIT_W-1:0] best;
    rgb_t             result;
    origin_t          origin;

    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign s1_fire       = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // column bookkeeping at the input transfer
    always_comb
    begin
        col_eff   = s_axis_tuser ? '0 : col_reg;
        first_eff = s_axis_tuser ? 1'b1 : first_row_reg;
        width_ext = CW'(width_reg);
        if (width_ext == '0)
        begin
            eff_width = CW'(1);
        end
        else if (width_ext > MAX_W_C)
        begin
            eff_width = MAX_W_C;
        end
        else
        begin
            eff_width = width_ext;
        end
        col_plus = CW'(col_eff) + CW'(1);
        row_wrap = (col_plus >= eff_width);
    end

    // neighbor selection, ties go to above
    always_comb
    begin
        above   = s1_first_reg ? BLACK : (s1_fwd_reg ? fwd_data_reg : rd_data_reg);
        left    = (s1_col_reg == '0) ? BLACK : left_reg;
        d_above = sq_dist(above, s1_src_reg);
        d_left  = sq_dist(left, s1_src_reg);
        if (d_left < d_above)
        begin
            best   = d_left;
            origin = ORIGIN_LEFT;
            result = left;
        end
        else
        begin
            best   = d_above;
            origin = ORIGIN_ABOVE;
            result = above;
        end
        if (best >= limit_reg)
        begin
            origin = ORIGIN_SOURCE;
            result = s1_src_reg;
        end
    end

    // line store, read before write on the same entry
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_data_reg <= row_mem[col_eff];
        end
        if (s1_fire)
        begin
            row_mem[s1_col_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            width_reg     <= WIDTH_RESET;
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= BLACK;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    CFG_MATCH_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_IMAGE_WIDTH: width_reg <= cfg_data[WIDTH_W-1:0];
                    default: ;
                endcase
            end

            if (in_fire)
            begin
                if (row_wrap)
                begin
                    col_reg       <= '0;
                    first_row_reg <= 1'b0;
                end
                else
                begin
                    col_reg       <= col_plus[CNT_W-1:0];
                    first_row_reg <= first_eff;
                end
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                left_reg      <= result;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_src_reg   <= s_axis_tdata;
            s1_col_reg   <= col_eff;
            s1_first_reg <= first_eff;
            // write of the item ahead lands on the entry just read
            s1_fwd_reg   <= s1_fire && (s1_col_reg == col_eff);
            fwd_data_reg <= result;
        end
        if (s1_fire)
        begin
            out_pix_reg    <= result;
            out_origin_reg <= origin;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_origin_reg, out_pix_reg};

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipe");

    a_fwd_col: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_fwd_reg) |-> (s1_col_reg == '0))
        else $error("forward on a column other than zero");

    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> $stable(rd_data_reg))
        else $error("line store data lost under stall");

    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[25:24] != 2'd3))
        else $error("illegal color origin");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// streams rgb pixels through the color region propagation block under random
// source gaps and sink stalls, with register writes between phases, and checks
// every output pixel against a cycle-free prediction of the line store logic
// ----------------------------------------------------------------------------
module testbench;

    import rcrp_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int PIXEL_TOTAL = 1150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HIGH_W      = CFG_DATA_W - WIDTH_W;

    typedef struct packed {
        rgb_t    color;
        origin_t origin;
    } pixel_out_t;

    // predicts the propagated pixels and holds them until they come out
    class pixel_scoreboard;
        rgb_t               line_mem [MAX_W];
        bit                 line_seen [MAX_W];
        rgb_t               last_out;
        int unsigned        col;
        bit                 top_row;
        logic [LIMIT_W-1:0] match_limit;
        logic [WIDTH_W-1:0] row_width;
        pixel_out_t         expected_q [$];
        int                 mismatches;

        function new();
            last_out    = BLACK;
            col         = 0;
            top_row     = 1'b1;
            match_limit = LIMIT_RESET;
            row_width   = WIDTH_RESET;
            mismatches  = 0;
            foreach (line_seen[i])
                line_seen[i] = 1'b0;
        endfunction

        function void set_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MATCH_LIMIT: match_limit = val[LIMIT_W-1:0];
                CFG_IMAGE_WIDTH: row_width   = val[WIDTH_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (row_width == 0)
                return 1;
            if (row_width > MAX_W)
                return MAX_W;
            return 32'(row_width);
        endfunction

        function int unsigned color_gap(input rgb_t a, input rgb_t b);
            int dr;
            int dg;
            int db;
            dr = int'(a.red) - int'(b.red);
            dg = int'(a.green) - int'(b.green);
            db = int'(a.blue) - int'(b.blue);
            return dr * dr + dg * dg + db * db;
        endfunction

        // true when the next pixel without a frame start would read a stale line entry
        function bit reads_unwritten();
            return !top_row && !line_seen[(col >= MAX_W) ? 0 : col];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_pixel(input rgb_t src, input bit frame_start);
            rgb_t        up;
            rgb_t        lf;
            int unsigned d_up;
            int unsigned d_lf;
            int unsigned best;
            pixel_out_t  res;
            if (frame_start)
            begin
                col     = 0;
                top_row = 1'b1;
            end
            if (col >= MAX_W)
                col = 0;
            up   = top_row ? BLACK : line_mem[col];
            lf   = (col == 0) ? BLACK : last_out;
            d_up = color_gap(up, src);
            d_lf = color_gap(lf, src);
            // a tie goes to the pixel above
            if (d_lf < d_up)
            begin
                best       = d_lf;
                res.color  = lf;
                res.origin = ORIGIN_LEFT;
            end
            else
            begin
                best       = d_up;
                res.color  = up;
                res.origin = ORIGIN_ABOVE;
            end
            if (best >= 32'(match_limit))
            begin
                res.color  = src;
                res.origin = ORIGIN_SOURCE;
            end
            line_mem[col]  = res.color;
            line_seen[col] = 1'b1;
            last_out       = res.color;
            if (col + 1 >= eff_width())
            begin
                col     = 0;
                top_row = 1'b0;
            end
            else
            begin
                col++;
            end
            expected_q.push_back(res);
        endfunction

        function void compare_field(input string what, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            end
        endfunction

        function void check_pixel(input logic [31:0] data);
            pixel_out_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: output transfer %h with no pixel expected", $time, data);
                return;
            end
            want = expected_q.pop_front();
            compare_field("red", want.color.red, data[7:0]);
            compare_field("green", want.color.green, data[15:8]);
            compare_field("blue", want.color.blue, data[23:16]);
            compare_field("origin", {6'd0, want.origin}, {6'd0, data[25:24]});
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    // red [7:0], green [15:8], blue [23:16]
    logic [23:0]           s_axis_tdata;
    // frame_start [0]
    logic                  s_axis_tuser;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // out_red [7:0], out_green [15:8], out_blue [23:16], color_origin [25:24]
    logic [31:0]           m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pixel_scoreboard board = new();
    bit              calm  = 1'b0;
    int              sent  = 0;

    raster_color_region_propagate_top #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
    end

    // sink side: random stall bursts, none near the end
    initial
    begin : pixel_sink
        m_axis_tready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 99) < 25)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_pixel(m_axis_tdata);
    end

    function automatic rgb_t shade(input int r, input int g, input int b);
        rgb_t c;
        c.red   = r[7:0];
        c.green = g[7:0];
        c.blue  = b[7:0];
        return c;
    endfunction

    function automatic logic [7:0] nudge(input logic [7:0] c, input int spread);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    task automatic send_pixel(input rgb_t px, input bit frame_start);
        if (!calm && $urandom_range(0, 99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tdata  <= px;
        s_axis_tuser  <= frame_start;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        board.note_pixel(px, frame_start);
        sent++;
    endtask

    // stop the stream and wait until every predicted pixel has come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        rgb_t                  base [4];
        rgb_t                  px;
        bit                    frame_start;
        logic [CFG_DATA_W-1:0] val;
        int                    spread;
        int                    n;
        int                    k;

        rst_n         <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tvalid <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_MATCH_LIMIT;
        cfg_data      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, first row after reset without a frame start
        send_pixel(shade(0, 0, 0), 1'b0);
        send_pixel(shade(255, 255, 255), 1'b0);
        send_pixel(shade(250, 245, 255), 1'b0);
        send_pixel(shade(9, 8, 7), 1'b0);
        settle();

        // narrow rows: copies from above and left, a tie, a frame start mid row
        write_reg(CFG_IMAGE_WIDTH, 18'd3);
        write_reg(CFG_MATCH_LIMIT, 18'd400);
        send_pixel(shade(100, 100, 100), 1'b1);
        send_pixel(shade(110, 100, 100), 1'b0);
        send_pixel(shade(0, 0, 255), 1'b0);
        send_pixel(shade(100, 100, 100), 1'b0);
        send_pixel(shade(105, 100, 100), 1'b0);
        send_pixel(shade(255, 0, 0), 1'b0);
        send_pixel(shade(0, 255, 0), 1'b0);
        send_pixel(shade(3, 250, 4), 1'b1);
        send_pixel(shade(7, 6, 5), 1'b0);
        settle();

        // width zero acts as one, limit zero never copies
        write_reg(CFG_IMAGE_WIDTH, 18'd0);
        write_reg(CFG_MATCH_LIMIT, 18'd0);
        send_pixel(shade(0, 0, 0), 1'b1);
        send_pixel(shade(0, 0, 0), 1'b0);
        send_pixel(shade(1, 0, 0), 1'b0);
        settle();

        // oversized width, full limit always copies
        write_reg(CFG_IMAGE_WIDTH, 18'd2047);
        write_reg(CFG_MATCH_LIMIT, 18'h3ffff);
        send_pixel(shade(255, 255, 255), 1'b1);
        send_pixel(shade(255, 255, 255), 1'b0);
        settle();
        // white against black sits exactly on this limit
        write_reg(CFG_MATCH_LIMIT, 18'd195075);
        send_pixel(shade(255, 255, 255), 1'b0);
        settle();
        write_reg(CFG_MATCH_LIMIT, 18'd195076);
        send_pixel(shade(255, 255, 255), 1'b1);
        settle();
        // shrink the width in the middle of a row
        write_reg(CFG_IMAGE_WIDTH, 18'd2);
        send_pixel(shade(1, 2, 3), 1'b0);
        send_pixel(shade(4, 5, 6), 1'b0);
        send_pixel(shade(200, 100, 50), 1'b0);

        while (sent < PIXEL_TOTAL)
        begin
            settle();
            if ($urandom_range(0, 3) != 0)
            begin
                k = $urandom_range(0, 11);
                case (k)
                    0: val = 18'd0;
                    1: val = 18'd1;
                    2: val = 18'd400;
                    3: val = 18'd195075;
                    4: val = 18'd195076;
                    5: val = 18'h3ffff;
                    6: val = CFG_DATA_W'($urandom);
                    default: val = CFG_DATA_W'($urandom_range(0, 3000));
                endcase
                write_reg(CFG_MATCH_LIMIT, val);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                k = $urandom_range(0, 9);
                case (k)
                    0: val = 18'd0;
                    1: val = 18'd1;
                    2: val = 18'd2;
                    8:
                    begin
                        k = $urandom_range(0, 2);
                        val = (k == 0) ? 18'd1024 : ((k == 1) ? 18'd1025 : 18'd2047);
                    end
                    9: val = CFG_DATA_W'($urandom_range(13, 64));
                    default: val = CFG_DATA_W'($urandom_range(3, 12));
                endcase
                // bits above the width field are dropped by the register
                if ($urandom_range(0, 7) == 0)
                    val[CFG_DATA_W-1:WIDTH_W] = HIGH_W'($urandom);
                write_reg(CFG_IMAGE_WIDTH, val);
            end

            foreach (base[i])
                base[i] = 24'($urandom);
            spread = $urandom_range(0, 40);
            n = $urandom_range(8, 90);
            if (n > PIXEL_TOTAL - sent)
                n = PIXEL_TOTAL - sent;
            frame_start = 1'($urandom_range(0, 1));

            for (int i = 0; i < n; i++)
            begin
                k = $urandom_range(0, 99);
                if (k < 8)
                begin
                    px = 24'($urandom);
                end
                else if (k < 14)
                begin
                    px.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    px.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    px.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                end
                else
                begin
                    px = base[2'($urandom_range(0, 3))];
                    px.red   = nudge(px.red, spread);
                    px.green = nudge(px.green, spread);
                    px.blue  = nudge(px.blue, spread);
                end
                if (i != 0)
                    frame_start = ($urandom_range(0, 99) < 3);
                // a grown width must not reach line entries never written
                if (board.reads_unwritten())
                    frame_start = 1'b1;
                calm = (sent >= PIXEL_TOTAL - 120);
                send_pixel(px, frame_start);
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: raster_color_region_propagate_top.f
src/rcrp_pkg.sv
src/raster_color_region_propagate_top.sv
tb/testbench.sv
